[design/rgbca_pkg.sv]
// ----------------------------------------------------------------------------
// rgbca_pkg: shared types and constants for the RGB555 color adjust block
// Register map indexes, input kinds, the fixed ramp table, the divide-by-255
// reciprocal and the byte clamp used by the pixel lanes.
// ----------------------------------------------------------------------------
package rgbca_pkg;

  typedef logic [7:0] chan_t;

  localparam int NUM_LANES = 3;

  // register index = paddr[3:2]
  localparam logic [1:0] REG_USE_RAMP   = 2'd0;
  localparam logic [1:0] REG_CONTRAST   = 2'd1;
  localparam logic [1:0] REG_BRIGHTNESS = 2'd2;
  localparam logic [1:0] REG_CURVE_EN   = 2'd3;

  // tuser kinds
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_CURVE = 1'b1;

  localparam logic [7:0] NEUTRAL_LEVEL = 8'd100;

  // floor(n / 255) = (n * RECIP_MULT) >> RECIP_SHIFT for n < 132626
  localparam logic [17:0] RECIP_MULT  = 18'd131587;
  localparam int          RECIP_SHIFT = 25;

  localparam chan_t RAMP_TABLE [32] = '{
    8'h00, 8'h01, 8'h03, 8'h06, 8'h0a, 8'h0f, 8'h15, 8'h1c,
    8'h24, 8'h2d, 8'h37, 8'h42, 8'h4e, 8'h5b, 8'h69, 8'h78,
    8'h88, 8'h90, 8'h98, 8'ha0, 8'ha8, 8'hb0, 8'hb8, 8'hc0,
    8'hc8, 8'hd0, 8'hd8, 8'he0, 8'he8, 8'hf0, 8'hf8, 8'hff
  };

  function automatic chan_t clamp_byte(input logic signed [10:0] v);
    chan_t r;
    if (v < 11'sd0) begin
      r = 8'd0;
    end else if (v > 11'sd255) begin
      r = 8'hff;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

endpackage

[design/rgbca_ram.sv]
// ----------------------------------------------------------------------------
// rgbca_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data held when re is low.
// ----------------------------------------------------------------------------
module rgbca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/rgb555_color_adjust.sv]
// ----------------------------------------------------------------------------
// rgb555_color_adjust: RGB555 to RGB888 converter with picture adjustments
// Widening or fixed ramp, contrast, brightness and a loadable gamma curve,
// three channel lanes in a six-stage pipeline.
// ----------------------------------------------------------------------------
//  channel   dir  beat                 payload
//  s_axis    in   tvalid & tready      tuser = op, tdata = pixel/index/value
//  m_axis    out  tvalid & tready      tdata = red/green/blue
//  apb       in   psel&penable&pwrite  4 registers at 0x0, 0x4, 0x8, 0xc
//
// One beat per cycle sustained while m_axis is ready; a pixel taken at one edge
// passes the six register stages (two multiplies, clamps, curve RAM), the first
// of which is loaded by the accepting edge, and is offered on m_axis from stage 6.
// Curve beats write the curve RAM as they enter stage 5 and leave no result.
// rst clears stage valids and restores register defaults; curve RAM is not
// cleared. Each stage holds while the next is full, so stalls lose nothing.
// ----------------------------------------------------------------------------
module rgb555_color_adjust (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // pixel[14:0], curve_index[22:15], curve_value[30:23]
  input  logic [0:0]  s_axis_tuser,  // op[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // red[7:0], green[15:8], blue[23:16]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int NL = rgbca_pkg::NUM_LANES;

  // configuration
  logic       use_ramp;
  logic [7:0] contrast_setting;
  logic [7:0] brightness_setting;
  logic       curve_enable;
  logic       cfg_wr;

  // pipeline control
  logic [6:1] vld;
  logic [6:1] rdy;
  logic       op1, op2, op3, op4, op5;
  logic [7:0] idx1, idx2, idx3, idx4;
  logic [7:0] val1, val2, val3, val4;

  // lane payload per stage
  rgbca_pkg::chan_t x1 [NL];
  rgbca_pkg::chan_t x2 [NL];
  rgbca_pkg::chan_t x3 [NL];
  rgbca_pkg::chan_t x4 [NL];
  rgbca_pkg::chan_t x5 [NL];
  rgbca_pkg::chan_t rd [NL];
  rgbca_pkg::chan_t out_data [NL];
  rgbca_pkg::chan_t out_data_q [NL];
  logic signed [17:0] num2 [NL];
  logic               neg3 [NL];
  logic [33:0]        prod3 [NL];

  // lane next values
  rgbca_pkg::chan_t   x1_next [NL];
  logic signed [17:0] cx [NL];
  logic signed [17:0] num2_next [NL];
  logic [16:0]        mag [NL];
  logic [33:0]        prod3_next [NL];
  logic [8:0]         quo [NL];
  logic signed [10:0] squo [NL];
  logic signed [10:0] con_sum [NL];
  rgbca_pkg::chan_t   x4_next [NL];
  logic signed [10:0] bri_sum [NL];
  rgbca_pkg::chan_t   x5_next [NL];
  logic [4:0]         v5 [NL];
  logic signed [8:0]  c9;
  logic signed [8:0]  b9;
  logic               ram_we;

  // --------------------------------------------------------------------------
  // APB registers
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      use_ramp           <= 1'b0;
      contrast_setting   <= rgbca_pkg::NEUTRAL_LEVEL;
      brightness_setting <= rgbca_pkg::NEUTRAL_LEVEL;
      curve_enable       <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        rgbca_pkg::REG_USE_RAMP:   use_ramp           <= pwdata[0];
        rgbca_pkg::REG_CONTRAST:   contrast_setting   <= pwdata[7:0];
        rgbca_pkg::REG_BRIGHTNESS: brightness_setting <= pwdata[7:0];
        rgbca_pkg::REG_CURVE_EN:   curve_enable       <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      rgbca_pkg::REG_USE_RAMP:   prdata = {31'd0, use_ramp};
      rgbca_pkg::REG_CONTRAST:   prdata = {24'd0, contrast_setting};
      rgbca_pkg::REG_BRIGHTNESS: prdata = {24'd0, brightness_setting};
      rgbca_pkg::REG_CURVE_EN:   prdata = {31'd0, curve_enable};
      default:                   prdata = 32'd0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Stage handshakes: a stage loads when empty or when it drains this cycle.
  // Curve beats retire out of stage 5.
  // --------------------------------------------------------------------------
  always_comb begin
    rdy[6] = !vld[6] | m_axis_tready;
    rdy[5] = !vld[5] | (op5 == rgbca_pkg::OP_CURVE) | rdy[6];
    rdy[4] = !vld[4] | rdy[5];
    rdy[3] = !vld[3] | rdy[4];
    rdy[2] = !vld[2] | rdy[3];
    rdy[1] = !vld[1] | rdy[2];
  end

  assign s_axis_tready = rdy[1];

  // --------------------------------------------------------------------------
  // Lane datapath
  // --------------------------------------------------------------------------
  always_comb begin
    c9 = $signed({1'b0, contrast_setting}) - 9'sd100;
    b9 = $signed({1'b0, brightness_setting}) - 9'sd100;
    for (int i = 0; i < NL; i++) begin
      // stage 1: widen or ramp
      v5[i] = s_axis_tdata[5*(NL-1-i) +: 5];
      x1_next[i] = use_ramp ? rgbca_pkg::RAMP_TABLE[v5[i]] : {v5[i], v5[i][4:2]};
      // stage 2: 2*c*x + 127
      cx[i] = c9 * $signed({1'b0, x1[i]});
      num2_next[i] = $signed({cx[i][16:0], 1'b0}) + 18'sd127;
      // stage 3: |num| / 255 by reciprocal
      mag[i] = num2[i][17] ? 17'(-num2[i]) : num2[i][16:0];
      prod3_next[i] = 34'(mag[i] * rgbca_pkg::RECIP_MULT);
      // stage 4: signed quotient toward zero, x - c + q, clamp
      quo[i] = prod3[i][rgbca_pkg::RECIP_SHIFT +: 9];
      squo[i] = neg3[i] ? -$signed({2'b00, quo[i]}) : $signed({2'b00, quo[i]});
      con_sum[i] = $signed({3'b000, x3[i]}) - 11'(c9) + squo[i];
      x4_next[i] = rgbca_pkg::clamp_byte(con_sum[i]);
      // stage 5: brightness, clamp; result also addresses the curve RAM
      bri_sum[i] = $signed({3'b000, x4[i]}) + 11'(b9);
      x5_next[i] = rgbca_pkg::clamp_byte(bri_sum[i]);
      // stage 6: curve select
      out_data[i] = curve_enable ? rd[i] : x5[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) vld[1] <= s_axis_tvalid;
      if (rdy[2]) vld[2] <= vld[1];
      if (rdy[3]) vld[3] <= vld[2];
      if (rdy[4]) vld[4] <= vld[3];
      if (rdy[5]) vld[5] <= vld[4];
      if (rdy[6]) vld[6] <= vld[5] & (op5 == rgbca_pkg::OP_PIXEL);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      op1  <= s_axis_tuser[0];
      idx1 <= s_axis_tdata[22:15];
      val1 <= s_axis_tdata[30:23];
      x1   <= x1_next;
    end
    if (rdy[2]) begin
      op2  <= op1;
      idx2 <= idx1;
      val2 <= val1;
      x2   <= x1;
      num2 <= num2_next;
    end
    if (rdy[3]) begin
      op3  <= op2;
      idx3 <= idx2;
      val3 <= val2;
      x3   <= x2;
      prod3 <= prod3_next;
      for (int i = 0; i < NL; i++) begin
        neg3[i] <= num2[i][17];
      end
    end
    if (rdy[4]) begin
      op4  <= op3;
      idx4 <= idx3;
      val4 <= val3;
      x4   <= x4_next;
    end
    if (rdy[5]) begin
      op5 <= op4;
      x5  <= x5_next;
    end
    if (rdy[6]) begin
      out_data_q <= out_data;
    end
  end

  assign m_axis_tvalid = vld[6];
  assign m_axis_tdata  = {out_data_q[2], out_data_q[1], out_data_q[0]};

  // --------------------------------------------------------------------------
  // Gamma curve: one copy per lane, all written alike, in stream order at
  // stage 5 entry so pixels see exactly the writes that came before them.
  // --------------------------------------------------------------------------
  assign ram_we = rdy[5] & vld[4] & (op4 == rgbca_pkg::OP_CURVE);

  for (genvar g = 0; g < NL; g++) begin : g_curve
    rgbca_ram #(
      .WIDTH (8),
      .DEPTH (256)
    ) u_curve (
      .clk   (clk),
      .we    (ram_we),
      .waddr (idx4),
      .wdata (val4),
      .re    (rdy[5]),
      .raddr (x5_next[g]),
      .rdata (rd[g])
    );
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_pixel_reaches_out: assert property (@(posedge clk) disable iff (rst)
    (vld[5] && op5 == rgbca_pkg::OP_PIXEL && rdy[6]) |=> m_axis_tvalid)
    else $error("pixel in stage 5 did not reach the output register");

  a_curve_no_result: assert property (@(posedge clk) disable iff (rst)
    (vld[5] && op5 == rgbca_pkg::OP_CURVE && rdy[6]) |=> !m_axis_tvalid)
    else $error("curve beat produced a result");

  a_stage4_holds: assert property (@(posedge clk) disable iff (rst)
    (vld[4] && !rdy[5]) |=> (vld[4] && $stable(op4) && $stable(idx4) && $stable(val4)))
    else $error("stalled stage 4 beat changed");

  a_ram_write_only_curve: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (vld[4] && !(vld[5] && !rdy[5])))
    else $error("curve RAM written while stage 5 is blocked");

endmodule
